// ===== hw/rtl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the 3D affine point transform: request and
// response payloads, opcodes, and the lane control and result bundles.
// ----------------------------------------------------------------------------
package apt_pkg;

  // payload field width and matrix shape
  localparam int FIELD_W   = 32;
  localparam int NUM_AXES  = 3;
  localparam int NUM_COEFS = 12;
  localparam int TRANS_ROW = 9;

  // request opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2
  } apt_op_t;

  // request payload
  typedef struct packed {
    logic [1:0]                opcode;
    logic [3:0]                coef_index;
    logic signed [FIELD_W-1:0] coef_value;
    logic signed [FIELD_W-1:0] x_in;
    logic signed [FIELD_W-1:0] y_in;
    logic signed [FIELD_W-1:0] z_in;
  } apt_req_t;

  // response payload
  typedef struct packed {
    logic signed [FIELD_W-1:0] x_out;
    logic signed [FIELD_W-1:0] y_out;
    logic signed [FIELD_W-1:0] z_out;
    logic                      saturated;
  } apt_rsp_t;

  // pipeline load enables for one lane
  typedef struct packed {
    logic load_mult;
    logic load_sum;
  } apt_lane_ctrl_t;

  // one lane's clipped column value
  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      clip;
  } apt_lane_res_t;

endpackage

// ===== hw/rtl/apt_lane.sv =====
// ----------------------------------------------------------------------------
// apt_lane
// One output column: three products, full precision sum, arithmetic scale
// down, optional translation add and saturation to the coordinate width.
// ----------------------------------------------------------------------------
module apt_lane import apt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  apt_lane_ctrl_t                ctrl,
  input  logic signed [COORD_WIDTH-1:0] vec [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] col [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] trans_in,
  input  logic                          use_trans,
  output apt_lane_res_t                 res
);

  localparam int PW  = 2 * COORD_WIDTH;
  localparam int SW  = PW + 2;
  localparam int QW  = SW - FRAC_BITS;
  localparam int RW  = (QW + 1 > COORD_WIDTH + 1) ? QW + 1 : COORD_WIDTH + 1;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [RW-1:0]          HI   = RW'(CMAX);
  localparam logic signed [RW-1:0]          LO   = RW'(CMIN);

  logic signed [PW-1:0]          prod [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] trans_m;
  logic signed [SW-1:0]          sum;
  logic signed [COORD_WIDTH-1:0] trans_s;
  logic signed [QW-1:0]          scaled;
  logic signed [RW-1:0]          total;
  logic signed [COORD_WIDTH-1:0] clipped;

  // multiply stage, translation captured with the operands
  always_ff @(posedge clk) begin
    if (ctrl.load_mult) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        prod[k] <= PW'(vec[k]) * PW'(col[k]);
      end
      trans_m <= use_trans ? trans_in : '0;
    end
  end

  // full precision sum stage
  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      sum     <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
      trans_s <= trans_m;
    end
  end

  // floor scale, translation add and clip
  always_comb begin
    scaled = $signed(sum[SW-1:FRAC_BITS]);
    total  = RW'(scaled) + RW'(trans_s);
    if (total > HI) begin
      clipped = CMAX;
    end else if (total < LO) begin
      clipped = CMIN;
    end else begin
      clipped = total[COORD_WIDTH-1:0];
    end
    res.value = FIELD_W'(clipped);
    res.clip  = (total > HI) || (total < LO);
  end

endmodule

// ===== hw/rtl/apt_merge.sv =====
// ----------------------------------------------------------------------------
// apt_merge
// Output register: gathers the three lane columns into one response and
// combines the lane clip flags.
// ----------------------------------------------------------------------------
module apt_merge import apt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          sum_valid,
  input  apt_lane_res_t lane_res [NUM_AXES],
  output logic          ready,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output apt_rsp_t      rsp
);

  logic     rsp_valid_next;
  apt_rsp_t rsp_next;

  // output slot frees when empty or when its transfer completes
  assign ready = !rsp_valid || !rsp_stall;

  // combine lanes
  always_comb begin
    rsp_next.x_out     = lane_res[0].value;
    rsp_next.y_out     = lane_res[1].value;
    rsp_next.z_out     = lane_res[2].value;
    rsp_next.saturated = lane_res[0].clip || lane_res[1].clip || lane_res[2].clip;
    rsp_valid_next     = ready ? sum_valid : rsp_valid;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ready && sum_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== hw/rtl/affine_point_transform_3d.sv =====
// ----------------------------------------------------------------------------
// affine_point_transform_3d
// Row-vector transform of 3D points and directions by a stored 4x3 affine
// matrix in signed fixed point, one lane per output column.
// ----------------------------------------------------------------------------
// A transform transfer is taken every clock cycle while req_stall is low;
// its response passes through a multiply stage (three multipliers in each
// of the three column lanes), a sum stage, and the output register that
// merges the lanes. Each stage holds its item while later stages are
// stalled and still takes a new one when it has room, so throughput is one
// item per cycle whenever the response side keeps up. A coefficient load is
// a single transfer, updates the matrix at once so the next transform sees
// it, and gives no response; opcode 3 and loads above index 11 do nothing.
// After reset the matrix is identity.
module affine_point_transform_3d import apt_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  apt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output apt_rsp_t rsp
);

  localparam logic signed [COORD_WIDTH-1:0] ONE =
    (FRAC_BITS >= COORD_WIDTH - 1) ? {1'b0, {(COORD_WIDTH-1){1'b1}}}
                                   : COORD_WIDTH'(1) << FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] coef [NUM_COEFS];
  logic signed [COORD_WIDTH-1:0] vec  [NUM_AXES];
  logic                          mult_valid;
  logic                          sum_valid;
  logic                          mult_ready;
  logic                          sum_ready;
  logic                          out_ready;
  logic                          req_xfer;
  logic                          is_xform;
  logic                          use_trans;
  apt_lane_ctrl_t                lane_ctrl;
  apt_lane_res_t                 lane_res [NUM_AXES];

  // stage handshake: a stage takes a new item when empty or when it moves on
  assign sum_ready  = !sum_valid || out_ready;
  assign mult_ready = !mult_valid || sum_ready;
  assign req_stall  = !mult_ready;
  assign req_xfer   = req_valid && !req_stall;
  assign is_xform   = (req.opcode == OP_POINT) || (req.opcode == OP_DIR);
  assign use_trans  = (req.opcode == OP_POINT);

  assign lane_ctrl.load_mult = req_xfer && is_xform;
  assign lane_ctrl.load_sum  = sum_ready && mult_valid;

  // input vector from the low coordinate bits
  assign vec[0] = $signed(req.x_in[COORD_WIDTH-1:0]);
  assign vec[1] = $signed(req.y_in[COORD_WIDTH-1:0]);
  assign vec[2] = $signed(req.z_in[COORD_WIDTH-1:0]);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mult_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (mult_ready) begin
        mult_valid <= req_valid && is_xform;
      end
      if (sum_ready) begin
        sum_valid <= mult_valid;
      end
    end
  end

  // coefficient store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= ((i % (NUM_AXES + 1)) == 0 && i < NUM_AXES * NUM_AXES) ? ONE : '0;
      end
    end else if (req_xfer && req.opcode == OP_LOAD &&
                 req.coef_index < 4'(NUM_COEFS)) begin
      coef[req.coef_index] <= $signed(req.coef_value[COORD_WIDTH-1:0]);
    end
  end

  // one lane per output column
  for (genvar c = 0; c < NUM_AXES; c++) begin : g_lane
    logic signed [COORD_WIDTH-1:0] col [NUM_AXES];

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_col
      assign col[k] = coef[k * NUM_AXES + c];
    end

    apt_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .vec       (vec),
      .col       (col),
      .trans_in  (coef[TRANS_ROW + c]),
      .use_trans (use_trans),
      .res       (lane_res[c])
    );
  end

  // lane merge and output register
  apt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .lane_res  (lane_res),
    .ready     (out_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // the input only stalls when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> mult_valid && sum_valid && rsp_valid && rsp_stall)
    else $error("input stalled with room in the pipeline");

  // a held multiply result is not lost while the sum stage is blocked
  a_mult_hold: assert property (@(posedge clk) disable iff (rst)
    mult_valid && !sum_ready |=> mult_valid)
    else $error("multiply stage dropped an item");

  // loads never create a response
  a_load_bubble: assert property (@(posedge clk) disable iff (rst)
    req_xfer && req.opcode == OP_LOAD |=> !mult_valid)
    else $error("load entered the transform pipeline");

  // reset leaves identity on the diagonal
  a_reset_ident: assert property (@(posedge clk)
    rst |=> coef[0] == ONE && coef[4] == ONE && coef[8] == ONE && coef[9] == '0)
    else $error("coefficient store not identity after reset");

endmodule

// ===== tb/affine_point_transform_3d_tb.sv =====
// ----------------------------------------------------------------------------
// affine_point_transform_3d_tb
// Self-checking bench for the 3D affine point transform. Coefficient loads,
// point and direction transforms and ignored requests are sent through the
// valid/stall request channel. Each accepted transform is predicted from a
// local copy of the 4x3 matrix with a wide accumulator, floor shift and
// 32-bit clipping. Responses are compared in order, field by field. The run
// covers directed corner cases and then random traffic under several idle
// and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_point_transform_3d_tb;
  import apt_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 175;
  localparam int DRAIN_CYCLES = 16;

  // opcode with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // clip bounds in the wide accumulator, unit value and coordinate extremes
  localparam logic signed [95:0] CLIP_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] CLIP_LO = -96'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [FIELD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] Q_MIN = 32'sh8000_0000;

  // matrix mirror and in-order store of predicted output vectors
  class transform_scoreboard;
    logic signed [FIELD_W-1:0] coefs [NUM_COEFS];
    apt_rsp_t pending_vectors [$];
    int failures;

    function new();
      foreach (coefs[i]) coefs[i] = '0;
      for (int a = 0; a < NUM_AXES; a++) coefs[a * NUM_AXES + a] = Q_ONE;
      failures = 0;
    endfunction

    // apply an accepted request: update the matrix or predict one vector
    function void note_request(apt_req_t r);
      logic signed [95:0] acc;
      logic signed [95:0] term;
      logic signed [95:0] coef;
      logic signed [FIELD_W-1:0] vec [NUM_AXES];
      logic signed [FIELD_W-1:0] col [NUM_AXES];
      logic clip;
      apt_rsp_t want;
      if (r.opcode == OP_LOAD) begin
        if (r.coef_index < NUM_COEFS) coefs[r.coef_index] = r.coef_value;
      end else if (r.opcode == OP_POINT || r.opcode == OP_DIR) begin
        vec[0] = $signed(r.x_in);
        vec[1] = $signed(r.y_in);
        vec[2] = $signed(r.z_in);
        clip = 1'b0;
        for (int c = 0; c < NUM_AXES; c++) begin
          // full precision dot product, then floor shift
          acc = '0;
          for (int k = 0; k < NUM_AXES; k++) begin
            term = vec[k];
            coef = coefs[k * NUM_AXES + c];
            acc += term * coef;
          end
          acc = acc >>> FRAC_BITS;
          if (r.opcode == OP_POINT) begin
            coef = coefs[TRANS_ROW + c];
            acc += coef;
          end
          if (acc > CLIP_HI) begin
            acc = CLIP_HI;
            clip = 1'b1;
          end else if (acc < CLIP_LO) begin
            acc = CLIP_LO;
            clip = 1'b1;
          end
          col[c] = acc[FIELD_W-1:0];
        end
        want.x_out = col[0];
        want.y_out = col[1];
        want.z_out = col[2];
        want.saturated = clip;
        pending_vectors.push_back(want);
      end
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, actual %h", name, want, got);
        failures++;
      end
    endfunction

    // compare one response transfer with the oldest prediction
    function void check_response(apt_rsp_t got);
      apt_rsp_t want;
      if (pending_vectors.size() == 0) begin
        $error("response with no transform outstanding: %h", got);
        failures++;
        return;
      end
      want = pending_vectors.pop_front();
      compare_field("x_out", want.x_out, got.x_out);
      compare_field("y_out", want.y_out, got.y_out);
      compare_field("z_out", want.z_out, got.z_out);
      compare_field("saturated", FIELD_W'(want.saturated), FIELD_W'(got.saturated));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  apt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  apt_rsp_t rsp;

  transform_scoreboard board = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;

  affine_point_transform_3d u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // response side: check accepted transfers, then pick next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);
    rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  function automatic apt_req_t load_req(logic [3:0] idx, logic signed [FIELD_W-1:0] val);
    apt_req_t r;
    r = '0;
    r.opcode = OP_LOAD;
    r.coef_index = idx;
    r.coef_value = val;
    r.x_in = $urandom();
    r.y_in = $urandom();
    r.z_in = $urandom();
    return r;
  endfunction

  function automatic apt_req_t xform_req(logic [1:0] op, logic signed [FIELD_W-1:0] x,
                                         logic signed [FIELD_W-1:0] y,
                                         logic signed [FIELD_W-1:0] z);
    apt_req_t r;
    r = '0;
    r.opcode = op;
    r.x_in = x;
    r.y_in = y;
    r.z_in = z;
    return r;
  endfunction

  // mostly modest Q16.16 values, sometimes extremes or raw bits
  function automatic logic signed [FIELD_W-1:0] rand_q16(int wild_pct);
    if ($urandom_range(0, 99) < wild_pct) begin
      case ($urandom_range(0, 3))
        0: return Q_MAX;
        1: return Q_MIN;
        default: return $urandom();
      endcase
    end
    return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // hold the request until the block takes it
  task automatic send_request(apt_req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
  endtask

  // random traffic: mostly transforms and loads, a little ignored noise
  task automatic random_phase(int idle_pct, int stall_pct);
    apt_req_t r;
    int done;
    int roll;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    done = 0;
    while (done < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        r = load_req(4'($urandom_range(NUM_COEFS, 15)), $urandom());
        if (roll < 2) begin
          r.opcode = OP_UNUSED;
          r.coef_index = 4'($urandom_range(0, 15));
        end
      end else if (roll < 25) begin
        r = load_req(4'($urandom_range(0, NUM_COEFS - 1)), rand_q16(8));
        done++;
      end else begin
        r = xform_req((roll < 62) ? OP_POINT : OP_DIR, rand_q16(25), rand_q16(25),
                      rand_q16(25));
        r.coef_index = 4'($urandom_range(0, 15));
        r.coef_value = $urandom();
        done++;
      end
      send_request(r);
    end
  endtask

  initial begin
    apt_req_t r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // identity pass-through, including extremes
    send_request(xform_req(OP_POINT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    send_request(xform_req(OP_DIR, Q_MAX, Q_MIN, -32'sd1));
    // index and value are don't-cares on a transform
    r = xform_req(OP_POINT, -32'sh0001_8000, Q_MAX, 32'sd0);
    r.coef_index = 4'd15;
    r.coef_value = Q_MIN;
    send_request(r);
    // unused opcode and out-of-range loads change nothing
    r = load_req(4'd0, Q_MAX);
    r.opcode = OP_UNUSED;
    send_request(r);
    send_request(load_req(4'd12, Q_MAX));
    send_request(load_req(4'd15, Q_MIN));
    // translation row pushes past both clip bounds
    send_request(load_req(4'(TRANS_ROW), Q_MAX));
    send_request(load_req(4'(TRANS_ROW + 1), Q_MIN));
    send_request(load_req(4'(TRANS_ROW + 2), Q_ONE));
    send_request(xform_req(OP_POINT, Q_ONE, -Q_ONE, 32'sd0));
    send_request(xform_req(OP_DIR, Q_ONE, -Q_ONE, 32'sd0));
    // three extreme products in one column overflow 64 bits
    send_request(load_req(4'd0, Q_MIN));
    send_request(load_req(4'd3, Q_MIN));
    send_request(load_req(4'd6, Q_MIN));
    send_request(xform_req(OP_DIR, Q_MIN, Q_MIN, Q_MIN));
    send_request(xform_req(OP_POINT, Q_MAX, Q_MAX, Q_MAX));
    // floor rounding and carry out of the fraction sums
    send_request(load_req(4'd0, 32'sd1));
    send_request(load_req(4'd3, 32'sh0000_8000));
    send_request(load_req(4'd6, 32'sh0000_8000));
    send_request(xform_req(OP_DIR, -32'sd1, 32'sd1, 32'sd1));
    send_request(xform_req(OP_DIR, -32'sd1, 32'sd0, 32'sd0));
    send_request(xform_req(OP_DIR, 32'sd0, 32'sd1, 32'sd1));

    random_phase(0, 0);
    random_phase(81, 0);
    random_phase(0, 81);
    random_phase(15, 15);
    req_valid <= 1'b0;

    // drain outstanding responses
    while (board.pending_vectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
